@@ rtl/tssr_pkg.sv @@
package tssr_pkg;

    localparam int SPRITE_COUNT = 40;
    localparam int TILE_COUNT   = 384;
    localparam int SCREEN_WIDTH = 160;
    localparam int SCREEN_ROWS  = 144;

    localparam int PLANE_REGION = 6144;
    localparam int PLANE_BYTES  = TILE_COUNT * 16;
    localparam int PLANE_WORDS  = TILE_COUNT * 8;
    localparam int MAP_BYTES    = 2048;
    localparam int ATTR_BYTES   = SPRITE_COUNT * 4;
    localparam int GROUPS       = (SCREEN_WIDTH + 7) / 8;
    localparam int LAST_COL     = GROUPS * 8 - 1;

    localparam int PLANE_AW = $clog2(PLANE_WORDS);
    localparam int MAP_AW   = $clog2(MAP_BYTES);
    localparam int SPR_AW   = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int LB_AW    = $clog2(SCREEN_WIDTH);
    localparam int CLEAR_LEN = (PLANE_WORDS > MAP_BYTES) ? PLANE_WORDS : MAP_BYTES;
    localparam int CLR_W    = $clog2(CLEAR_LEN);

    localparam int SPRITE_Y_BIAS = 16;
    localparam int SPRITE_X_BIAS = 8;
    localparam int WIN_X_BIAS    = 7;

    localparam logic [1:0] KIND_VRAM   = 2'd0;
    localparam logic [1:0] KIND_ATTR   = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    localparam logic [2:0] REG_LCDC = 3'd0;
    localparam logic [2:0] REG_BGP  = 3'd1;
    localparam logic [2:0] REG_OBP0 = 3'd2;
    localparam logic [2:0] REG_OBP1 = 3'd3;
    localparam logic [2:0] REG_SCX  = 3'd4;
    localparam logic [2:0] REG_SCY  = 3'd5;
    localparam logic [2:0] REG_WY   = 3'd6;
    localparam logic [2:0] REG_WX   = 3'd7;

    localparam int LCDC_BG_ON    = 0;
    localparam int LCDC_SPR_ON   = 1;
    localparam int LCDC_BG_MAP   = 3;
    localparam int LCDC_UNSIGNED = 4;
    localparam int LCDC_WIN_ON   = 5;
    localparam int LCDC_WIN_MAP  = 6;

    localparam int FLAG_BEHIND = 7;
    localparam int FLAG_YFLIP  = 6;
    localparam int FLAG_XFLIP  = 5;
    localparam int FLAG_PAL1   = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] offset;
        logic [7:0]  data;
        logic [7:0]  row;
    } t_in;

    typedef struct packed {
        logic [15:0] shades;
        logic [4:0]  group;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       v;
        logic [7:0] x;
        logic [1:0] sh;
    } t_layer;

    typedef struct packed {
        t_layer behind;
        t_layer front;
    } t_line;

    typedef struct packed {
        logic                plane_en;
        logic                map_en;
        logic                attr_en;
        logic                clear;
        logic [PLANE_AW-1:0] plane_addr;
        logic                lane;
        logic [MAP_AW-1:0]   map_addr;
        logic [SPR_AW-1:0]   attr_addr;
        logic [1:0]          attr_lane;
        logic [7:0]          data;
    } t_vram_wr;

    typedef struct packed {
        logic [PLANE_AW-1:0] plane_addr;
        logic [MAP_AW-1:0]   map_addr;
        logic [SPR_AW-1:0]   attr_addr;
    } t_vram_rd;

    typedef struct packed {
        logic             wr_en;
        logic             merge;
        logic             front;
        logic [7:0]       x;
        logic [1:0]       sh;
        logic [LB_AW-1:0] wr_addr;
    } t_lb_op;

    function automatic logic [1:0] pix_index(input logic [7:0] lo, input logic [7:0] hi,
                                             input logic [2:0] px);
        logic [2:0] sh;
        sh = 3'd7 - px;
        return {hi[sh], lo[sh]};
    endfunction

    function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] c);
        return 2'(pal >> {c, 1'b0});
    endfunction

endpackage

@@ rtl/tssr_vram.sv @@
module tssr_vram (
    input  logic              i_clk,
    input  tssr_pkg::t_vram_wr i_wr,
    input  tssr_pkg::t_vram_rd i_rd,
    output logic [15:0]       o_plane_q,
    output logic [7:0]        o_map_q,
    output logic [31:0]       o_attr_q
);
    import tssr_pkg::*;

    logic [15:0] r_plane [PLANE_WORDS];
    logic [7:0]  r_map   [MAP_BYTES];
    logic [31:0] r_attr  [SPRITE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_wr.plane_en) begin
            if (i_wr.clear) begin
                r_plane[i_wr.plane_addr] <= '0;
            end else if (i_wr.lane) begin
                r_plane[i_wr.plane_addr][15:8] <= i_wr.data;
            end else begin
                r_plane[i_wr.plane_addr][7:0] <= i_wr.data;
            end
        end
        if (i_wr.map_en) begin
            r_map[i_wr.map_addr] <= i_wr.data;
        end
        if (i_wr.attr_en) begin
            if (i_wr.clear) begin
                r_attr[i_wr.attr_addr] <= '0;
            end else begin
                unique case (i_wr.attr_lane)
                    2'd0: r_attr[i_wr.attr_addr][7:0]   <= i_wr.data;
                    2'd1: r_attr[i_wr.attr_addr][15:8]  <= i_wr.data;
                    2'd2: r_attr[i_wr.attr_addr][23:16] <= i_wr.data;
                    2'd3: r_attr[i_wr.attr_addr][31:24] <= i_wr.data;
                endcase
            end
        end
        o_plane_q <= r_plane[i_rd.plane_addr];
        o_map_q   <= r_map[i_rd.map_addr];
        o_attr_q  <= r_attr[i_rd.attr_addr];
    end

endmodule

@@ rtl/tssr_linebuf.sv @@
module tssr_linebuf (
    input  logic                         i_clk,
    input  logic [tssr_pkg::LB_AW-1:0]   i_rd_addr,
    input  tssr_pkg::t_lb_op             i_op,
    output tssr_pkg::t_line              o_q
);
    import tssr_pkg::*;

    t_line  r_mem [SCREEN_WIDTH];
    t_line  wr_data;
    t_layer sel;
    logic   take;

    always_comb begin
        wr_data = o_q;
        sel     = i_op.front ? o_q.front : o_q.behind;
        take    = !sel.v || (i_op.x < sel.x);
        if (!i_op.merge) begin
            wr_data = '0;
        end else if (take) begin
            if (i_op.front) begin
                wr_data.front = '{v: 1'b1, x: i_op.x, sh: i_op.sh};
            end else begin
                wr_data.behind = '{v: 1'b1, x: i_op.x, sh: i_op.sh};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.wr_en) begin
            r_mem[i_op.wr_addr] <= wr_data;
        end
        o_q <= r_mem[i_rd_addr];
    end

endmodule

@@ rtl/tile_sprite_scanline_renderer.sv @@
// Line renderer for tile/sprite video. After reset a clearing pass zeroes
// video memory, attributes and the line buffer; configuration writes are
// taken meanwhile, items are not. A render row runs one shared fetch/compare
// unit under a sequencer: each sprite is scanned by an attribute read and a
// row test; a sprite on the row gets a plane fetch, then for each pixel a line
// buffer read and, when an opaque on-screen pixel is found, a merge into the
// line buffer. Then each column takes a map fetch, a tile fetch and a pixel
// step, and each group of eight an output step, which an output stall holds.
// The one read port per video memory and the line buffer read-modify-write set
// this order of steps. The block stalls input while a row is in progress;
// results leave through an output register.
module tile_sprite_scanline_renderer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tssr_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tssr_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data
);
    import tssr_pkg::*;

    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_SPR_ADDR  = 4'd2;
    localparam logic [3:0] ST_SPR_TEST  = 4'd3;
    localparam logic [3:0] ST_SPR_PLANE = 4'd4;
    localparam logic [3:0] ST_SPR_COL   = 4'd5;
    localparam logic [3:0] ST_SPR_MERGE = 4'd6;
    localparam logic [3:0] ST_COL_MAP   = 4'd7;
    localparam logic [3:0] ST_COL_TILE  = 4'd8;
    localparam logic [3:0] ST_COL_PIX   = 4'd9;
    localparam logic [3:0] ST_EMIT      = 4'd10;

    logic [3:0]        r_state;
    logic [CLR_W-1:0]  r_clr;
    logic [7:0]        r_cfg [8];
    logic [7:0]        r_row;
    logic [SPR_AW-1:0] r_spr_idx;
    logic [31:0]       r_spr;
    logic              r_tile_ok;
    logic [7:0]        r_lo;
    logic [7:0]        r_hi;
    logic [2:0]        r_j;
    logic [LB_AW-1:0]  r_mcol;
    logic [1:0]        r_msh;
    logic [7:0]        r_col;
    t_line             r_line;
    logic [15:0]       r_shades;
    t_out              r_out;
    logic              r_out_valid;

    t_vram_wr          vram_wr;
    t_vram_rd          vram_rd;
    logic [15:0]       plane_q;
    logic [7:0]        map_q;
    logic [31:0]       attr_q;
    t_lb_op            lb_op;
    logic [LB_AW-1:0]  lb_rd_addr;
    t_line             lb_q;

    logic [7:0]  lcdc;
    logic        accept;
    logic [7:0]  a_y, a_tile, a_fl;
    logic [9:0]  dy;
    logic        hit;
    logic [2:0]  trow_s;
    logic [7:0]  s_x, s_fl;
    logic [2:0]  px_s;
    logic [1:0]  c_s;
    logic [8:0]  sum_s;
    logic        onscr_s;
    logic [8:0]  col_s;
    logic [7:0]  pal_s;
    logic        spr_last;
    logic [7:0]  by, wy, bx, wrel;
    logic        win_row, in_win;
    logic [8:0]  tile_b;
    logic [2:0]  trow_b, px_b;
    logic [1:0]  c_b;
    logic        col_on;
    logic [1:0]  s_out;
    logic        out_free;
    logic        emit_go;

    tssr_vram u_vram (
        .i_clk     (i_clk),
        .i_wr      (vram_wr),
        .i_rd      (vram_rd),
        .o_plane_q (plane_q),
        .o_map_q   (map_q),
        .o_attr_q  (attr_q)
    );

    tssr_linebuf u_linebuf (
        .i_clk     (i_clk),
        .i_rd_addr (lb_rd_addr),
        .i_op      (lb_op),
        .o_q       (lb_q)
    );

    assign lcdc        = r_cfg[REG_LCDC];
    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit_go     = (r_state == ST_EMIT) && out_free;

    always_comb begin
        a_y    = attr_q[7:0];
        a_tile = attr_q[23:16];
        a_fl   = attr_q[31:24];
        dy     = 10'(r_row) + 10'(SPRITE_Y_BIAS) - 10'(a_y);
        hit    = dy < 10'd8;
        trow_s = dy[2:0] ^ {3{a_fl[FLAG_YFLIP]}};

        s_x     = r_spr[15:8];
        s_fl    = r_spr[31:24];
        px_s    = r_j ^ {3{s_fl[FLAG_XFLIP]}};
        c_s     = r_tile_ok ? pix_index(r_lo, r_hi, px_s) : 2'd0;
        sum_s   = {1'b0, s_x} + 9'(r_j);
        col_s   = sum_s - 9'(SPRITE_X_BIAS);
        onscr_s = (sum_s >= 9'(SPRITE_X_BIAS)) && (10'(col_s) < 10'(SCREEN_WIDTH));
        pal_s   = s_fl[FLAG_PAL1] ? r_cfg[REG_OBP1] : r_cfg[REG_OBP0];
        spr_last = (r_spr_idx == SPR_AW'(SPRITE_COUNT - 1));

        by      = r_cfg[REG_SCY] + r_row;
        wy      = r_row - r_cfg[REG_WY];
        bx      = r_cfg[REG_SCX] + r_col;
        wrel    = r_col + 8'(WIN_X_BIAS) - r_cfg[REG_WX];
        win_row = lcdc[LCDC_BG_ON] && lcdc[LCDC_WIN_ON] && (r_cfg[REG_WY] <= r_row);
        in_win  = win_row && ((9'(r_col) + 9'(WIN_X_BIAS)) >= 9'(r_cfg[REG_WX]));
        tile_b  = {~map_q[7] & ~lcdc[LCDC_UNSIGNED], map_q};
        trow_b  = in_win ? wy[2:0] : by[2:0];
        px_b    = in_win ? wrel[2:0] : bx[2:0];
        c_b     = r_tile_ok ? pix_index(plane_q[7:0], plane_q[15:8], px_b) : 2'd0;
        col_on  = 10'(r_col) < 10'(SCREEN_WIDTH);

        priority if (!col_on) begin
            s_out = 2'd0;
        end else if (r_line.front.v) begin
            s_out = r_line.front.sh;
        end else if (lcdc[LCDC_BG_ON] && (c_b != 2'd0)) begin
            s_out = pal_shade(r_cfg[REG_BGP], c_b);
        end else if (r_line.behind.v) begin
            s_out = r_line.behind.sh;
        end else begin
            s_out = pal_shade(r_cfg[REG_BGP], 2'd0);
        end
    end

    always_comb begin
        vram_wr    = '0;
        vram_rd    = '0;
        lb_op      = '0;
        lb_rd_addr = '0;
        vram_wr.data = i_in.data;
        unique case (r_state)
            ST_CLEAR: begin
                vram_wr.clear      = 1'b1;
                vram_wr.data       = '0;
                vram_wr.plane_en   = (32'(r_clr) < PLANE_WORDS);
                vram_wr.map_en     = (32'(r_clr) < MAP_BYTES);
                vram_wr.attr_en    = (32'(r_clr) < SPRITE_COUNT);
                vram_wr.plane_addr = r_clr[PLANE_AW-1:0];
                vram_wr.map_addr   = r_clr[MAP_AW-1:0];
                vram_wr.attr_addr  = r_clr[SPR_AW-1:0];
                lb_op.wr_en        = (32'(r_clr) < SCREEN_WIDTH);
                lb_op.wr_addr      = r_clr[LB_AW-1:0];
            end
            ST_IDLE: begin
                vram_wr.plane_addr = i_in.offset[PLANE_AW:1];
                vram_wr.lane       = i_in.offset[0];
                vram_wr.map_addr   = i_in.offset[MAP_AW-1:0];
                vram_wr.attr_addr  = i_in.offset[SPR_AW+1:2];
                vram_wr.attr_lane  = i_in.offset[1:0];
                if (accept && (i_in.kind == KIND_VRAM)) begin
                    vram_wr.plane_en = (32'(i_in.offset) < PLANE_REGION)
                                    && (32'(i_in.offset) < PLANE_BYTES);
                    vram_wr.map_en   = (32'(i_in.offset) >= PLANE_REGION);
                end
                if (accept && (i_in.kind == KIND_ATTR)) begin
                    vram_wr.attr_en = (32'(i_in.offset) < ATTR_BYTES);
                end
            end
            ST_SPR_ADDR: begin
                vram_rd.attr_addr = r_spr_idx;
            end
            ST_SPR_TEST: begin
                vram_rd.plane_addr = PLANE_AW'({1'b0, a_tile, trow_s});
            end
            ST_SPR_PLANE: begin
            end
            ST_SPR_COL: begin
                lb_rd_addr = col_s[LB_AW-1:0];
            end
            ST_SPR_MERGE: begin
                lb_op.wr_en   = 1'b1;
                lb_op.merge   = 1'b1;
                lb_op.front   = !s_fl[FLAG_BEHIND];
                lb_op.x       = s_x;
                lb_op.sh      = r_msh;
                lb_op.wr_addr = r_mcol;
            end
            ST_COL_MAP: begin
                vram_rd.map_addr = in_win ? {lcdc[LCDC_WIN_MAP], wy[7:3], wrel[7:3]}
                                          : {lcdc[LCDC_BG_MAP], by[7:3], bx[7:3]};
                lb_rd_addr = r_col[LB_AW-1:0];
            end
            ST_COL_TILE: begin
                vram_rd.plane_addr = PLANE_AW'({tile_b, trow_b});
            end
            ST_COL_PIX: begin
                lb_op.wr_en   = col_on;
                lb_op.wr_addr = r_col[LB_AW-1:0];
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_cfg[k] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && !emit_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_W'(CLEAR_LEN - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    r_row     <= i_in.row;
                    r_spr_idx <= '0;
                    r_col     <= '0;
                    if (accept && (i_in.kind == KIND_RENDER)
                            && (32'(i_in.row) < SCREEN_ROWS)) begin
                        r_state <= lcdc[LCDC_SPR_ON] ? ST_SPR_ADDR : ST_COL_MAP;
                    end
                end
                ST_SPR_ADDR: begin
                    r_state <= ST_SPR_TEST;
                end
                ST_SPR_TEST: begin
                    r_spr     <= attr_q;
                    r_tile_ok <= (10'(a_tile) < 10'(TILE_COUNT));
                    if (hit) begin
                        r_state <= ST_SPR_PLANE;
                    end else if (spr_last) begin
                        r_state <= ST_COL_MAP;
                    end else begin
                        r_spr_idx <= r_spr_idx + 1'b1;
                        r_state   <= ST_SPR_ADDR;
                    end
                end
                ST_SPR_PLANE: begin
                    r_lo    <= plane_q[7:0];
                    r_hi    <= plane_q[15:8];
                    r_j     <= '0;
                    r_state <= ST_SPR_COL;
                end
                ST_SPR_COL, ST_SPR_MERGE: begin
                    r_mcol <= col_s[LB_AW-1:0];
                    r_msh  <= pal_shade(pal_s, c_s);
                    if ((r_state == ST_SPR_COL) && (c_s != 2'd0) && onscr_s) begin
                        r_state <= ST_SPR_MERGE;
                    end else if (r_j != 3'd7) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_SPR_COL;
                    end else if (spr_last) begin
                        r_state <= ST_COL_MAP;
                    end else begin
                        r_spr_idx <= r_spr_idx + 1'b1;
                        r_state   <= ST_SPR_ADDR;
                    end
                end
                ST_COL_MAP: begin
                    r_state <= ST_COL_TILE;
                end
                ST_COL_TILE: begin
                    r_tile_ok <= (10'(tile_b) < 10'(TILE_COUNT));
                    r_line    <= lb_q;
                    r_state   <= ST_COL_PIX;
                end
                ST_COL_PIX: begin
                    r_shades <= {r_shades[13:0], s_out};
                    if (r_col[2:0] == 3'd7) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= ST_COL_MAP;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_out_valid  <= 1'b1;
                        r_out.shades <= r_shades;
                        r_out.group  <= r_col[7:3];
                        r_out.last   <= (r_col == 8'(LAST_COL));
                        if (r_col == 8'(LAST_COL)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= ST_COL_MAP;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_spr_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPR_ADDR) |-> lcdc[LCDC_SPR_ON])
        else $error("sprite scan with sprites disabled");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |=> (r_state != ST_CLEAR))
        else $error("clearing pass re-entered");

    a_last_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.group == 5'(GROUPS - 1)))
        else $error("last flag on wrong group");

    a_emit_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_col[2:0] == 3'd7))
        else $error("group emitted off a group boundary");

endmodule

@@ verif/testbench.sv @@
module testbench;
    import tssr_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    t_in            i_in;
    logic           o_out_valid;
    logic           i_out_stall;
    t_out           o_out;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [7:0]     i_cfg_data;

    tile_sprite_scanline_renderer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [7:0] vram_planes [PLANE_BYTES];
    logic [7:0] vram_maps [MAP_BYTES];
    logic [7:0] oam [ATTR_BYTES];
    logic [7:0] regs [8];
    logic [1:0] line_buf [SCREEN_WIDTH];

    t_in  pending_items [$];
    t_out expected_groups [$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cycles;
    int   errors;
    int   renders_done;
    int   groups_checked;
    int   writes_done;

    function automatic logic [1:0] tile_pixel(int tile, int trow, int px);
        int b;
        int sh;
        if (tile >= TILE_COUNT) return 2'd0;
        b  = tile * 16 + (trow & 7) * 2;
        sh = 7 - (px & 7);
        return {vram_planes[b + 1][sh], vram_planes[b][sh]};
    endfunction

    function automatic logic [1:0] shade_of(logic [7:0] pal, logic [1:0] c);
        return pal[2 * c +: 2];
    endfunction

    function automatic int tile_number(logic [7:0] code);
        if (regs[REG_LCDC][LCDC_UNSIGNED]) return code;
        return (code < 128) ? 256 + code : code;
    endfunction

    function automatic void draw_sprites(int r, bit behind);
        int list [$];
        int n;
        int j;
        int v;
        int diff;
        int trow;
        int col;
        int px;
        logic [7:0] pal;
        logic [1:0] c;
        for (int i = 0; i < SPRITE_COUNT; i++) begin
            diff = r - (int'(oam[i * 4]) - 16);
            if (diff >= 0 && diff < 8 && (oam[i * 4 + 3][FLAG_BEHIND] == behind))
                list = {list, i};
        end
        n = list.size();
        for (int i = 1; i < n; i++) begin
            v = list[i];
            j = i - 1;
            while (j >= 0 && oam[list[j] * 4 + 1] > oam[v * 4 + 1]) begin
                list[j + 1] = list[j];
                j--;
            end
            list[j + 1] = v;
        end
        for (int i = n - 1; i >= 0; i--) begin
            v    = list[i] * 4;
            trow = r - (int'(oam[v]) - 16);
            pal  = oam[v + 3][FLAG_PAL1] ? regs[REG_OBP1] : regs[REG_OBP0];
            if (oam[v + 3][FLAG_YFLIP]) trow = 7 - trow;
            for (int k = 0; k < 8; k++) begin
                col = int'(oam[v + 1]) - 8 + k;
                px  = oam[v + 3][FLAG_XFLIP] ? 7 - k : k;
                c   = tile_pixel(oam[v + 2], trow, px);
                if (c != 0 && col >= 0 && col < SCREEN_WIDTH) line_buf[col] = shade_of(pal, c);
            end
        end
    endfunction

    function automatic void predict_row(int r);
        logic [7:0] lcd;
        bit   win;
        int   win_left;
        int   bg_base;
        int   win_base;
        int   by;
        int   wrow;
        int   wxp;
        int   bx;
        int   m;
        logic [1:0] c;
        t_out g;
        lcd      = regs[REG_LCDC];
        win      = lcd[LCDC_BG_ON] && lcd[LCDC_WIN_ON] && regs[REG_WY] <= r;
        win_left = int'(regs[REG_WX]) - 7;
        bg_base  = lcd[LCDC_BG_MAP] ? 1024 : 0;
        win_base = lcd[LCDC_WIN_MAP] ? 1024 : 0;
        by       = (regs[REG_SCY] + r) & 255;
        wrow     = (r - regs[REG_WY]) & 255;
        for (int x = 0; x < SCREEN_WIDTH; x++) line_buf[x] = shade_of(regs[REG_BGP], 2'd0);
        if (lcd[LCDC_SPR_ON]) draw_sprites(r, 1'b1);
        if (lcd[LCDC_BG_ON]) begin
            for (int x = 0; x < SCREEN_WIDTH; x++) begin
                if (win && x >= win_left) begin
                    wxp = x - win_left;
                    m   = (win_base + 32 * (wrow / 8) + ((wxp / 8) & 31)) & (MAP_BYTES - 1);
                    c   = tile_pixel(tile_number(vram_maps[m]), wrow, wxp);
                end else begin
                    bx = (regs[REG_SCX] + x) & 255;
                    m  = (bg_base + 32 * (by / 8) + bx / 8) & (MAP_BYTES - 1);
                    c  = tile_pixel(tile_number(vram_maps[m]), by, bx);
                end
                if (c != 0) line_buf[x] = shade_of(regs[REG_BGP], c);
            end
        end
        if (lcd[LCDC_SPR_ON]) draw_sprites(r, 1'b0);
        for (int gi = 0; gi < GROUPS; gi++) begin
            g.shades = '0;
            for (int k = 0; k < 8; k++)
                g.shades = {g.shades[13:0],
                            (gi * 8 + k < SCREEN_WIDTH) ? line_buf[gi * 8 + k] : 2'd0};
            g.group = 5'(gi);
            g.last  = (gi == GROUPS - 1);
            expected_groups = {expected_groups, g};
        end
        renders_done++;
    endfunction

    function automatic void apply_item(t_in it);
        case (it.kind)
            KIND_VRAM: begin
                if (it.offset < PLANE_REGION) begin
                    if (it.offset < PLANE_BYTES) vram_planes[it.offset] = it.data;
                end else begin
                    vram_maps[it.offset - PLANE_REGION] = it.data;
                end
                writes_done++;
            end
            KIND_ATTR: begin
                if (it.offset < ATTR_BYTES) oam[it.offset] = it.data;
                writes_done++;
            end
            KIND_RENDER: if (it.row < SCREEN_ROWS) predict_row(it.row);
            default: ;
        endcase
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    task automatic push_item(logic [1:0] k, int off, int d, int r);
        t_in it;
        it.kind   = k;
        it.offset = 13'(off);
        it.data   = 8'(d);
        it.row    = 8'(r);
        pending_items = {pending_items, it};
    endtask

    task automatic push_random_item();
        int p;
        int off;
        int d;
        p = $urandom_range(99);
        if (p < 50) begin
            off = ($urandom_range(3) == 0) ? $urandom_range(8191, 6144) : $urandom_range(6143);
            push_item(KIND_VRAM, off, $urandom_range(255), $urandom_range(255));
        end else if (p < 75) begin
            off = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(ATTR_BYTES - 1);
            d   = $urandom_range(255);
            if (off % 4 == 0 && $urandom_range(3) != 0) d = $urandom_range(175, 10);
            push_item(KIND_ATTR, off, d, $urandom_range(255));
        end else if (p < 95) begin
            push_item(KIND_RENDER, $urandom_range(8191), $urandom_range(255),
                      ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(143));
        end else begin
            push_item(KIND_NONE, $urandom_range(8191), $urandom_range(255), $urandom_range(143));
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        regs[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_groups.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_regs(logic [7:0] lcd, logic [7:0] bgp, logic [7:0] p0, logic [7:0] p1,
                             logic [7:0] sx, logic [7:0] sy, logic [7:0] wy, logic [7:0] wx);
        write_reg(REG_LCDC, lcd);
        write_reg(REG_BGP, bgp);
        write_reg(REG_OBP0, p0);
        write_reg(REG_OBP1, p1);
        write_reg(REG_SCX, sx);
        write_reg(REG_SCY, sy);
        write_reg(REG_WY, wy);
        write_reg(REG_WX, wx);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("testbench: done, errors");
        $finish;
    end

    // driver: hold a stalled transaction, otherwise offer the next one
    bit in_fire;
    always @(posedge i_clk) begin
        in_fire = i_in_valid && !o_in_stall;
        if (in_fire) apply_item(i_in);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in       <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: count down a long hold-off, otherwise stall at random
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_groups.size() == 0) begin
                report("unexpected transaction", o_out, 0);
            end else begin
                want = expected_groups.pop_front();
                if (o_out.shades !== want.shades) report("shades", o_out.shades, want.shades);
                if (o_out.group !== want.group) report("group", o_out.group, want.group);
                if (o_out.last !== want.last) report("last", o_out.last, want.last);
                groups_checked++;
            end
        end
    end

    initial begin
        errors = 0; renders_done = 0; groups_checked = 0; writes_done = 0;
        hold_cycles = 0; send_idle_pct = 23; recv_idle_pct = 56;
        i_in = '0; i_in_valid = 1'b0; i_out_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        foreach (vram_planes[i]) vram_planes[i] = '0;
        foreach (vram_maps[i]) vram_maps[i] = '0;
        foreach (oam[i]) oam[i] = '0;
        foreach (regs[i]) regs[i] = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_regs(8'hFF, 8'hE4, 8'h1B, 8'hD2, 8'd0, 8'd0, 8'd0, 8'd0);
        push_item(KIND_RENDER, 0, 0, 0);
        push_item(KIND_VRAM, 0, 8'hFF, 0);
        push_item(KIND_VRAM, 1, 8'h0F, 0);
        push_item(KIND_VRAM, 6143, 8'hA5, 0);
        push_item(KIND_VRAM, 6142, 8'h5A, 0);
        push_item(KIND_VRAM, 6144, 8'h00, 0);
        push_item(KIND_VRAM, 8191, 8'hFF, 0);
        push_item(KIND_VRAM, 7168, 8'h7F, 0);
        push_item(KIND_VRAM, 256 * 16, 8'hC3, 0);
        push_item(KIND_VRAM, 256 * 16 + 1, 8'h3C, 0);
        push_item(KIND_ATTR, 0, 16, 0);
        push_item(KIND_ATTR, 1, 0, 0);
        push_item(KIND_ATTR, 2, 0, 0);
        push_item(KIND_ATTR, 3, 8'hF0, 0);
        push_item(KIND_ATTR, 156, 8'd16, 0);
        push_item(KIND_ATTR, 157, 8'd168, 0);
        push_item(KIND_ATTR, 158, 8'hFF, 0);
        push_item(KIND_ATTR, 159, 8'h20, 0);
        push_item(KIND_ATTR, 160, 8'hFF, 0);
        push_item(KIND_ATTR, 8191, 8'hFF, 0);
        push_item(KIND_NONE, 8191, 8'hFF, 8'hFF);
        push_item(KIND_RENDER, 8191, 8'hFF, 0);
        push_item(KIND_RENDER, 0, 0, 143);
        push_item(KIND_RENDER, 0, 0, 144);
        push_item(KIND_RENDER, 0, 0, 255);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'd255, 8'd255, 8'd255, 8'd255);
                1: load_regs(8'h7B, 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'd40, 8'd3);
                2: load_regs(8'h63, 8'hE4, 8'hFF, 8'h00, 8'd5, 8'd200, 8'd0, 8'd7);
                default: load_regs(8'h33, 8'($urandom_range(255)), 8'h6C, 8'h93,
                                   8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(143)), 8'($urandom_range(166)));
            endcase
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 56 : 0;
            recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 23 : 0;
            if (ph == 2) hold_cycles = 4000;
            for (int n = 0; n < 108; n++) push_random_item();
            wait_drained();
        end

        $display("covered %0d writes and %0d rendered rows, %0d groups checked",
                 writes_done, renders_done, groups_checked);
        $display("four register settings, stalls on both sides and one long output hold-off");
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
